>>> src/rdi_pkg.sv
package rdi_pkg;

  localparam int CoordWidth = 32;
  localparam int FracBits   = 16;
  localparam int ProdWidth  = 2 * CoordWidth + 1;
  localparam int CfgIdxWidth = 3;

  localparam logic [CfgIdxWidth-1:0] RegCenterX  = 3'd0;
  localparam logic [CfgIdxWidth-1:0] RegCenterY  = 3'd1;
  localparam logic [CfgIdxWidth-1:0] RegCenterZ  = 3'd2;
  localparam logic [CfgIdxWidth-1:0] RegNormalX  = 3'd3;
  localparam logic [CfgIdxWidth-1:0] RegNormalY  = 3'd4;
  localparam logic [CfgIdxWidth-1:0] RegNormalZ  = 3'd5;
  localparam logic [CfgIdxWidth-1:0] RegDiameter = 3'd6;

  typedef logic signed [CoordWidth-1:0] coord_t;
  typedef logic signed [CoordWidth:0]   diff_t;
  typedef logic        [CoordWidth-2:0] dist_t;

  typedef struct packed {
    coord_t origin_x;
    coord_t origin_y;
    coord_t origin_z;
    coord_t dir_x;
    coord_t dir_y;
    coord_t dir_z;
    dist_t  best_t;
  } in_t;

  typedef struct packed {
    logic  hit;
    dist_t nearest_t;
  } out_t;

  // ray data that rides along with the dot products and the divider
  typedef struct packed {
    diff_t  d_x;
    diff_t  d_y;
    diff_t  d_z;
    coord_t v_x;
    coord_t v_y;
    coord_t v_z;
    dist_t  best;
  } side_t;

  // drop the fraction bits of a magnitude product, saturate, apply sign
  function automatic coord_t sat_shift(input logic [ProdWidth-1:0] prod, input logic neg,
                                       input int frac);
    logic [ProdWidth-1:0]  sh;
    logic [CoordWidth-1:0] lim;
    sh  = prod >> frac;
    lim = neg ? {1'b1, {(CoordWidth-1){1'b0}}} : {1'b0, {(CoordWidth-1){1'b1}}};
    if (sh > ProdWidth'(lim)) begin
      sh = ProdWidth'(lim);
    end
    return neg ? coord_t'(-sh[CoordWidth-1:0]) : coord_t'(sh[CoordWidth-1:0]);
  endfunction

  function automatic coord_t sat_sum(input logic signed [CoordWidth+1:0] s);
    logic signed [CoordWidth+1:0] hi;
    logic signed [CoordWidth+1:0] lo;
    hi = {3'b000, {(CoordWidth-1){1'b1}}};
    lo = {3'b111, {(CoordWidth-1){1'b0}}};
    if (s > hi) begin
      return coord_t'(hi[CoordWidth-1:0]);
    end else if (s < lo) begin
      return coord_t'(lo[CoordWidth-1:0]);
    end
    return coord_t'(s[CoordWidth-1:0]);
  endfunction

endpackage

>>> src/rdi_dot.sv
module rdi_dot #(
  parameter int FRAC_BITS = rdi_pkg::FracBits
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 valid_i,
  input  rdi_pkg::diff_t       vec_i  [3],
  input  rdi_pkg::coord_t      norm_i [3],
  output logic                 valid_o,
  output rdi_pkg::coord_t      dot_o
);

  localparam int W  = rdi_pkg::CoordWidth;
  localparam int PW = rdi_pkg::ProdWidth;

  logic                           v1_q, v2_q;
  logic [rdi_pkg::ProdWidth-1:0]  prod_q [3];
  logic                           neg_q  [3];
  logic [rdi_pkg::ProdWidth-1:0]  prod_d [3];
  logic                           neg_d  [3];
  logic [W:0]                     mx     [3];
  logic [W-1:0]                   mn     [3];
  logic signed [W+1:0]            sum_d;
  rdi_pkg::coord_t                dot_q;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      mx[i]     = vec_i[i][W] ? -vec_i[i] : vec_i[i];
      mn[i]     = norm_i[i][W-1] ? -norm_i[i] : norm_i[i];
      prod_d[i] = PW'(mx[i]) * PW'(mn[i]);
      neg_d[i]  = vec_i[i][W] ^ norm_i[i][W-1];
    end
  end

  always_comb begin
    sum_d = '0;
    for (int i = 0; i < 3; i++) begin
      sum_d = sum_d + (W+2)'(rdi_pkg::sat_shift(prod_q[i], neg_q[i], FRAC_BITS));
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
    end else begin
      v1_q <= valid_i;
      v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    prod_q <= prod_d;
    neg_q  <= neg_d;
    dot_q  <= rdi_pkg::sat_sum(sum_d);
  end

  assign valid_o = v2_q;
  assign dot_o   = dot_q;

endmodule

>>> src/rdi_div.sv
module rdi_div #(
  parameter int FRAC_BITS = rdi_pkg::FracBits
) (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   valid_i,
  input  rdi_pkg::coord_t                        a_i,
  input  rdi_pkg::coord_t                        b_i,
  input  rdi_pkg::side_t                         side_i,
  output logic                                   valid_o,
  output logic                                   miss_o,
  output logic [rdi_pkg::CoordWidth+FRAC_BITS-1:0] quot_o,
  output rdi_pkg::side_t                         side_o
);

  localparam int W  = rdi_pkg::CoordWidth;
  localparam int QW = W + FRAC_BITS;

  logic            v_q    [QW+1];
  logic            miss_q [QW+1];
  logic [W-1:0]    num_q  [QW+1];
  logic [W-1:0]    den_q  [QW+1];
  logic [W-1:0]    rem_q  [QW+1];
  logic [QW-1:0]   quot_q [QW+1];
  rdi_pkg::side_t  side_q [QW+1];

  logic            miss_d;

  // miss when b is zero or a and b are nonzero with the same sign
  assign miss_d = (b_i == '0) || (a_i[W-1] && b_i[W-1]) ||
                  (!a_i[W-1] && a_i != '0 && !b_i[W-1]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q[0] <= 1'b0;
    end else begin
      v_q[0] <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    miss_q[0] <= miss_d;
    num_q[0]  <= a_i[W-1] ? W'(-a_i) : W'(a_i);
    den_q[0]  <= b_i[W-1] ? W'(-b_i) : W'(b_i);
    rem_q[0]  <= '0;
    quot_q[0] <= '0;
    side_q[0] <= side_i;
  end

  // one quotient bit per stage, restoring
  for (genvar k = 0; k < QW; k++) begin : g_step
    localparam int Pos = QW - 1 - k;
    logic         dbit;
    logic [W:0]   trial;
    logic [W:0]   diff;
    logic         ge;
    logic [W-1:0] rem_d;
    logic [QW-1:0] quot_d;

    if (Pos >= FRAC_BITS) begin : g_num
      assign dbit = num_q[k][Pos-FRAC_BITS];
    end else begin : g_zero
      assign dbit = 1'b0;
    end

    always_comb begin
      trial  = {rem_q[k], dbit};
      diff   = trial - {1'b0, den_q[k]};
      ge     = trial >= {1'b0, den_q[k]};
      rem_d  = ge ? diff[W-1:0] : trial[W-1:0];
      quot_d = {quot_q[k][QW-2:0], ge};
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[k+1] <= 1'b0;
      end else begin
        v_q[k+1] <= v_q[k];
      end
    end

    always_ff @(posedge clk_i) begin
      miss_q[k+1] <= miss_q[k];
      num_q[k+1]  <= num_q[k];
      den_q[k+1]  <= den_q[k];
      rem_q[k+1]  <= rem_d;
      quot_q[k+1] <= quot_d;
      side_q[k+1] <= side_q[k];
    end
  end

  assign valid_o = v_q[QW];
  assign miss_o  = miss_q[QW];
  assign quot_o  = quot_q[QW];
  assign side_o  = side_q[QW];

endmodule

>>> src/rdi_rim.sv
module rdi_rim #(
  parameter int FRAC_BITS = rdi_pkg::FracBits
) (
  input  logic                                     clk_i,
  input  logic                                     rst_ni,
  input  logic                                     valid_i,
  input  logic                                     miss_i,
  input  logic [rdi_pkg::CoordWidth+FRAC_BITS-1:0] quot_i,
  input  rdi_pkg::side_t                           side_i,
  input  rdi_pkg::dist_t                           diameter_i,
  output logic                                     valid_o,
  output rdi_pkg::out_t                            res_o
);

  localparam int W  = rdi_pkg::CoordWidth;
  localparam int QW = W + FRAC_BITS;
  localparam int PW = rdi_pkg::ProdWidth;

  logic              v1_q, v2_q, v3_q, v4_q;
  logic              miss1_q, miss2_q, miss3_q;
  rdi_pkg::dist_t    t1_q, t2_q, t3_q, best1_q, best2_q, best3_q;
  rdi_pkg::diff_t    d1_q   [3];
  logic [PW-1:0]     prod1_q [3];
  logic              neg1_q [3];
  rdi_pkg::coord_t   p2_q   [3];
  logic [2*W-1:0]    sq3_q  [3];
  logic [2*W-3:0]    dd3_q;
  rdi_pkg::out_t     res_q;

  rdi_pkg::dist_t    t_d;
  logic              miss1_d;
  rdi_pkg::coord_t   vv     [3];
  rdi_pkg::diff_t    dd     [3];
  logic [W-1:0]      vm     [3];
  logic [PW-1:0]     prod_d [3];
  logic [W-1:0]      pm     [3];
  logic [2*W+1:0]    s_d;
  logic [2*W+3:0]    s4_d;
  logic              in_d;

  always_comb begin
    vv[0] = side_i.v_x;
    vv[1] = side_i.v_y;
    vv[2] = side_i.v_z;
    dd[0] = side_i.d_x;
    dd[1] = side_i.d_y;
    dd[2] = side_i.d_z;
    t_d     = quot_i[W-2:0];
    miss1_d = miss_i || (|quot_i[QW-1:W-1]) || (t_d > side_i.best);
    for (int i = 0; i < 3; i++) begin
      vm[i]     = vv[i][W-1] ? W'(-vv[i]) : W'(vv[i]);
      prod_d[i] = PW'(vm[i]) * PW'(t_d);
      pm[i]     = p2_q[i][W-1] ? W'(-p2_q[i]) : W'(p2_q[i]);
    end
    s_d  = (2*W+2)'(sq3_q[0]) + (2*W+2)'(sq3_q[1]) + (2*W+2)'(sq3_q[2]);
    s4_d = {s_d, 2'b00};
    in_d = s4_d <= (2*W+4)'(dd3_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
    end else begin
      v1_q <= valid_i;
      v2_q <= v1_q;
      v3_q <= v2_q;
      v4_q <= v3_q;
    end
  end

  always_ff @(posedge clk_i) begin
    miss1_q <= miss1_d;
    t1_q    <= t_d;
    best1_q <= side_i.best;
    for (int i = 0; i < 3; i++) begin
      d1_q[i]    <= dd[i];
      prod1_q[i] <= prod_d[i];
      neg1_q[i]  <= vv[i][W-1];
    end
    // hit point relative to the center
    miss2_q <= miss1_q;
    t2_q    <= t1_q;
    best2_q <= best1_q;
    for (int i = 0; i < 3; i++) begin
      p2_q[i] <= rdi_pkg::sat_sum({d1_q[i][W], d1_q[i]} +
                 (W+2)'(rdi_pkg::sat_shift(prod1_q[i], neg1_q[i], FRAC_BITS)));
    end
    miss3_q <= miss2_q;
    t3_q    <= t2_q;
    best3_q <= best2_q;
    for (int i = 0; i < 3; i++) begin
      sq3_q[i] <= (2*W)'(pm[i]) * (2*W)'(pm[i]);
    end
    dd3_q <= (2*W-2)'(diameter_i) * (2*W-2)'(diameter_i);
    res_q.hit       <= !miss3_q && in_d;
    res_q.nearest_t <= (!miss3_q && in_d) ? t3_q : best3_q;
  end

  assign valid_o = v4_q;
  assign res_o   = res_q;

endmodule

>>> src/ray_disk_intersect.sv
// Channel   Direction  Handshake               Payload
// input     in         start, busy             in_i (rdi_pkg::in_t)
// result    out        res_strobe_o            res_o (rdi_pkg::out_t)
// config    in         cfg_valid_i, cfg_ready_o cfg_index_i, cfg_data_i
//
// Takes one ray per cycle; busy stays low. Each result passes the input
// register, the dot product stages, the divider, which retires one
// quotient bit per stage, and the rim check stages.
// Reset clears the valid bits of every stage and loads the register defaults.
// Results are strobed for one cycle and are never held back.
module ray_disk_intersect #(
  parameter int FRAC_BITS = rdi_pkg::FracBits
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               start,
  output logic                               busy,
  input  rdi_pkg::in_t                       in_i,
  output logic                               res_strobe_o,
  output rdi_pkg::out_t                      res_o,
  input  logic                               cfg_valid_i,
  output logic                               cfg_ready_o,
  input  logic [rdi_pkg::CfgIdxWidth-1:0]    cfg_index_i,
  input  logic [rdi_pkg::CoordWidth-1:0]     cfg_data_i
);

  localparam int W  = rdi_pkg::CoordWidth;
  localparam int QW = W + FRAC_BITS;

  rdi_pkg::coord_t center_q [3];
  rdi_pkg::coord_t normal_q [3];
  rdi_pkg::dist_t  diam_q;

  logic            v0_q;
  rdi_pkg::side_t  side0_q;
  rdi_pkg::side_t  side_d;
  rdi_pkg::side_t  sdl_q [2];

  rdi_pkg::diff_t  dvec [3];
  rdi_pkg::diff_t  vvec [3];
  logic            a_v, b_v;
  rdi_pkg::coord_t a_dot, b_dot;

  logic            dv_v, dv_miss;
  logic [QW-1:0]   dv_quot;
  rdi_pkg::side_t  dv_side;

  assign busy        = 1'b0;
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      center_q[0] <= '0;
      center_q[1] <= '0;
      center_q[2] <= '0;
      normal_q[0] <= '0;
      normal_q[1] <= '0;
      normal_q[2] <= rdi_pkg::coord_t'(W'(1) << FRAC_BITS);
      diam_q      <= '0;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        rdi_pkg::RegCenterX:  center_q[0] <= cfg_data_i;
        rdi_pkg::RegCenterY:  center_q[1] <= cfg_data_i;
        rdi_pkg::RegCenterZ:  center_q[2] <= cfg_data_i;
        rdi_pkg::RegNormalX:  normal_q[0] <= cfg_data_i;
        rdi_pkg::RegNormalY:  normal_q[1] <= cfg_data_i;
        rdi_pkg::RegNormalZ:  normal_q[2] <= cfg_data_i;
        rdi_pkg::RegDiameter: diam_q      <= cfg_data_i[W-2:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    side_d.d_x  = {in_i.origin_x[W-1], in_i.origin_x} - {center_q[0][W-1], center_q[0]};
    side_d.d_y  = {in_i.origin_y[W-1], in_i.origin_y} - {center_q[1][W-1], center_q[1]};
    side_d.d_z  = {in_i.origin_z[W-1], in_i.origin_z} - {center_q[2][W-1], center_q[2]};
    side_d.v_x  = in_i.dir_x;
    side_d.v_y  = in_i.dir_y;
    side_d.v_z  = in_i.dir_z;
    side_d.best = in_i.best_t;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v0_q <= 1'b0;
    end else begin
      v0_q <= start;
    end
  end

  // hold the ray beside the two dot product stages
  always_ff @(posedge clk_i) begin
    side0_q  <= side_d;
    sdl_q[0] <= side0_q;
    sdl_q[1] <= sdl_q[0];
  end

  always_comb begin
    dvec[0] = side0_q.d_x;
    dvec[1] = side0_q.d_y;
    dvec[2] = side0_q.d_z;
    vvec[0] = {side0_q.v_x[W-1], side0_q.v_x};
    vvec[1] = {side0_q.v_y[W-1], side0_q.v_y};
    vvec[2] = {side0_q.v_z[W-1], side0_q.v_z};
  end

  rdi_dot #(.FRAC_BITS(FRAC_BITS)) u_dot_a (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (v0_q),
    .vec_i   (dvec),
    .norm_i  (normal_q),
    .valid_o (a_v),
    .dot_o   (a_dot)
  );

  rdi_dot #(.FRAC_BITS(FRAC_BITS)) u_dot_b (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (v0_q),
    .vec_i   (vvec),
    .norm_i  (normal_q),
    .valid_o (b_v),
    .dot_o   (b_dot)
  );

  rdi_div #(.FRAC_BITS(FRAC_BITS)) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (a_v & b_v),
    .a_i     (a_dot),
    .b_i     (b_dot),
    .side_i  (sdl_q[1]),
    .valid_o (dv_v),
    .miss_o  (dv_miss),
    .quot_o  (dv_quot),
    .side_o  (dv_side)
  );

  rdi_rim #(.FRAC_BITS(FRAC_BITS)) u_rim (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .valid_i    (dv_v),
    .miss_i     (dv_miss),
    .quot_i     (dv_quot),
    .side_i     (dv_side),
    .diameter_i (diam_q),
    .valid_o    (res_strobe_o),
    .res_o      (res_o)
  );

endmodule

>>> dv/testbench.sv
`timescale 1ns / 100ps

module testbench;

  localparam longint SMax  = 64'sd2147483647;
  localparam longint SMin  = -64'sd2147483648;
  localparam int     Limit = 400000;
  localparam logic [rdi_pkg::CfgIdxWidth-1:0] RegUnused = 3'd7;

  logic clk_i;
  logic rst_ni;
  logic start;
  logic busy;
  rdi_pkg::in_t  in_i;
  logic res_strobe_o;
  rdi_pkg::out_t res_o;
  logic cfg_valid_i;
  logic cfg_ready_o;
  logic [rdi_pkg::CfgIdxWidth-1:0] cfg_index_i;
  logic [rdi_pkg::CoordWidth-1:0]  cfg_data_i;

  ray_disk_intersect dut (
    .clk_i, .rst_ni, .start, .busy, .in_i, .res_strobe_o, .res_o,
    .cfg_valid_i, .cfg_ready_o, .cfg_index_i, .cfg_data_i
  );

  // disk mirror
  longint      disk_cx, disk_cy, disk_cz, disk_nx, disk_ny, disk_nz;
  logic [30:0] disk_diam;

  rdi_pkg::in_t  ray_q[$];
  rdi_pkg::out_t hit_q[$];
  int   errors;
  int   cycles;
  int   idle_pct;
  logic took;

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  task automatic report(input string what);
    errors++;
    $display("mismatch at cycle %0d: %s", cycles, what);
  endtask

  function automatic longint sat_word(input longint v);
    if (v > SMax) return SMax;
    if (v < SMin) return SMin;
    return v;
  endfunction

  function automatic longint fix_mul(input longint x, input longint y);
    logic [127:0] p;
    logic         neg;
    longint       lim;
    neg = (x < 0) != (y < 0);
    p = 128'(x < 0 ? -x : x) * 128'(y < 0 ? -y : y);
    p = p >> rdi_pkg::FracBits;
    lim = neg ? 64'sd2147483648 : SMax;
    if (p > 128'(lim)) p = 128'(lim);
    return neg ? -longint'(p[63:0]) : longint'(p[63:0]);
  endfunction

  function automatic longint dot_normal(input longint x, input longint y, input longint z);
    return sat_word(fix_mul(x, disk_nx) + fix_mul(y, disk_ny) + fix_mul(z, disk_nz));
  endfunction

  function automatic longint mag(input longint v);
    return v < 0 ? -v : v;
  endfunction

  function automatic rdi_pkg::out_t disk_hit(input rdi_pkg::in_t r);
    rdi_pkg::out_t o;
    longint        dx, dy, dz, a, b, q, px, py, pz;
    logic [127:0]  s, d2;
    dx = longint'(r.origin_x) - disk_cx;
    dy = longint'(r.origin_y) - disk_cy;
    dz = longint'(r.origin_z) - disk_cz;
    a = dot_normal(dx, dy, dz);
    b = dot_normal(longint'(r.dir_x), longint'(r.dir_y), longint'(r.dir_z));
    o.hit = 1'b0;
    o.nearest_t = r.best_t;
    if (b == 0 || (a < 0 && b < 0) || (a > 0 && b > 0)) return o;
    q = (mag(a) << rdi_pkg::FracBits) / mag(b);
    if (q > SMax || q > longint'({33'd0, r.best_t})) return o;
    px = sat_word(dx + fix_mul(longint'(r.dir_x), q));
    py = sat_word(dy + fix_mul(longint'(r.dir_y), q));
    pz = sat_word(dz + fix_mul(longint'(r.dir_z), q));
    s = 128'(mag(px)) * 128'(mag(px)) + 128'(mag(py)) * 128'(mag(py))
      + 128'(mag(pz)) * 128'(mag(pz));
    d2 = 128'(disk_diam) * 128'(disk_diam);
    if ((s << 2) <= d2) begin
      o.hit = 1'b1;
      o.nearest_t = q[30:0];
    end
    return o;
  endfunction

  task automatic write_reg(input logic [rdi_pkg::CfgIdxWidth-1:0] idx,
                           input logic [31:0] data);
    @(negedge clk_i);
    cfg_valid_i = 1'b1;
    cfg_index_i = idx;
    cfg_data_i  = data;
    do @(posedge clk_i); while (!cfg_ready_o);
    case (idx)
      rdi_pkg::RegCenterX:  disk_cx = longint'(rdi_pkg::coord_t'(data));
      rdi_pkg::RegCenterY:  disk_cy = longint'(rdi_pkg::coord_t'(data));
      rdi_pkg::RegCenterZ:  disk_cz = longint'(rdi_pkg::coord_t'(data));
      rdi_pkg::RegNormalX:  disk_nx = longint'(rdi_pkg::coord_t'(data));
      rdi_pkg::RegNormalY:  disk_ny = longint'(rdi_pkg::coord_t'(data));
      rdi_pkg::RegNormalZ:  disk_nz = longint'(rdi_pkg::coord_t'(data));
      rdi_pkg::RegDiameter: disk_diam = data[30:0];
      default: ;
    endcase
    @(negedge clk_i);
    cfg_valid_i = 1'b0;
  endtask

  task automatic set_disk(input logic [31:0] cx, cy, cz, nx, ny, nz, diam);
    write_reg(rdi_pkg::RegCenterX, cx);
    write_reg(rdi_pkg::RegCenterY, cy);
    write_reg(rdi_pkg::RegCenterZ, cz);
    write_reg(rdi_pkg::RegNormalX, nx);
    write_reg(rdi_pkg::RegNormalY, ny);
    write_reg(rdi_pkg::RegNormalZ, nz);
    write_reg(rdi_pkg::RegDiameter, diam);
  endtask

  // wait out every outstanding result plus the pipeline depth
  task automatic drain();
    while (ray_q.size() != 0 || start || hit_q.size() != 0) @(posedge clk_i);
    repeat (70) @(posedge clk_i);
  endtask

  function automatic logic [31:0] small_val(input int span);
    return 32'($signed($urandom_range(2 * span)) - span);
  endfunction

  function automatic logic [31:0] pick_extreme();
    case ($urandom_range(4))
      0: return 32'h7fff_ffff;
      1: return 32'h8000_0000;
      2: return 32'h0;
      3: return 32'hffff_ffff;
      default: return $urandom;
    endcase
  endfunction

  function automatic rdi_pkg::in_t make_ray(input bit wide);
    rdi_pkg::in_t r;
    if (wide) begin
      r = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom, 31'($urandom)};
    end else begin
      r.origin_x = rdi_pkg::coord_t'(longint'(rdi_pkg::coord_t'(small_val(1 << 19)))
                                     + disk_cx);
      r.origin_y = rdi_pkg::coord_t'(longint'(rdi_pkg::coord_t'(small_val(1 << 19)))
                                     + disk_cy);
      r.origin_z = rdi_pkg::coord_t'(longint'(rdi_pkg::coord_t'(small_val(1 << 19)))
                                     + disk_cz);
      r.dir_x = small_val(1 << 17);
      r.dir_y = small_val(1 << 17);
      r.dir_z = small_val(1 << 17);
      case ($urandom_range(3))
        0: r.best_t = 31'($urandom_range(1 << 20));
        1: r.best_t = 31'h7fff_ffff;
        default: r.best_t = 31'($urandom_range(1 << 24));
      endcase
    end
    return r;
  endfunction

  // driver: hold an unaccepted beat, otherwise pull the next ray or idle
  always @(negedge clk_i) begin
    if (rst_ni && !(start && !took)) begin
      if (ray_q.size() != 0 && !($urandom_range(99) < idle_pct)) begin
        in_i  <= ray_q.pop_front();
        start <= 1'b1;
      end else begin
        start <= 1'b0;
      end
    end
  end

  // monitor: predict on accept, check on strobe
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    took <= start && !busy;
    if (rst_ni && start && !busy) hit_q.push_back(disk_hit(in_i));
    if (rst_ni && res_strobe_o) begin
      if (hit_q.size() == 0) begin
        report("result with nothing expected");
      end else begin
        if (res_o.hit !== hit_q[0].hit)
          report($sformatf("hit %0b, expected %0b", res_o.hit, hit_q[0].hit));
        if (res_o.nearest_t !== hit_q[0].nearest_t)
          report($sformatf("nearest_t %h, expected %h", res_o.nearest_t,
                           hit_q[0].nearest_t));
        void'(hit_q.pop_front());
      end
    end
    if (cycles > Limit) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  initial begin
    int pct[4];
    rdi_pkg::in_t r;
    pct = '{0, 52, 0, 6};
    errors = 0;
    cycles = 0;
    took = 1'b0;
    idle_pct = 0;
    start = 1'b0;
    in_i = '0;
    cfg_valid_i = 1'b0;
    cfg_index_i = '0;
    cfg_data_i = '0;
    disk_cx = 0; disk_cy = 0; disk_cz = 0;
    disk_nx = 0; disk_ny = 0; disk_nz = 64'sd65536;
    disk_diam = '0;
    rst_ni = 1'b0;
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // reset disk: only a hit point exactly at the center counts
    ray_q.push_back('{0, 0, 32'h1_0000, 0, 0, 32'hffff_0000, 31'h1_0000});
    ray_q.push_back('{1, 0, 32'h1_0000, 0, 0, 32'hffff_0000, 31'h1_0000});
    drain();
    set_disk(0, 0, 0, 0, 0, 32'h1_0000, 31'h4_0000);
    ray_q.push_back('{0, 0, 32'h1_0000, 0, 0, 32'hffff_0000, 31'h1_0000}); // t == best
    ray_q.push_back('{0, 0, 32'h1_0000, 0, 0, 32'hffff_0000, 31'h0_ffff}); // just short
    ray_q.push_back('{32'h2_0000, 0, 32'h1_0000, 0, 0, 32'hffff_0000, 31'h1_0000}); // rim
    ray_q.push_back('{32'h2_0001, 0, 32'h1_0000, 0, 0, 32'hffff_0000, 31'h1_0000});
    ray_q.push_back('{0, 0, 32'h1_0000, 0, 0, 32'hffff_ffff, 31'h7fff_ffff}); // huge t
    ray_q.push_back('{0, 0, 0, 32'h1_0000, 0, 32'h1_0000, 31'h0}); // zero offset
    ray_q.push_back('{0, 0, 32'h1_0000, 0, 0, 32'h1_0000, 31'h7fff_ffff}); // same sign
    ray_q.push_back('{0, 0, 32'h1_0000, 32'h1_0000, 0, 0, 31'h7fff_ffff}); // parallel
    ray_q.push_back('{32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff, 32'h8000_0000,
                      32'h8000_0000, 32'h8000_0000, 31'h7fff_ffff});
    ray_q.push_back('{32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h7fff_ffff,
                      32'h7fff_ffff, 32'h7fff_ffff, 31'h7fff_ffff});
    drain();
    set_disk(32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff, 32'h7fff_ffff,
             32'h8000_0000, 32'h7fff_ffff, 31'h7fff_ffff);
    write_reg(RegUnused, 32'hdead_beef);
    for (int i = 0; i < 6; i++) ray_q.push_back(make_ray(i % 2));
    drain();
    set_disk(0, 0, 0, 0, 0, 0, 31'h7fff_ffff); // zero normal
    for (int i = 0; i < 6; i++) ray_q.push_back(make_ray(i % 2));
    drain();

    for (int ph = 0; ph < 16; ph++) begin
      idle_pct = pct[ph % 4];
      if (ph % 5 == 4) begin
        set_disk(pick_extreme(), pick_extreme(), pick_extreme(), pick_extreme(),
                 pick_extreme(), pick_extreme(), pick_extreme());
      end else begin
        set_disk(small_val(1 << 22), small_val(1 << 22), small_val(1 << 22),
                 small_val(1 << 17), small_val(1 << 17), small_val(1 << 17),
                 32'($urandom_range(1 << 20)));
      end
      if (ph == 7) write_reg(RegUnused, $urandom);
      for (int i = 0; i < 105; i++) begin
        r = make_ray($urandom_range(9) == 0);
        ray_q.push_back(r);
      end
      drain();
    end

    if (errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
